// ===== design/load_address_predictor_table_assert.svh =====
// Assertion macros shared by the load address predictor RTL.
`ifndef LOAD_ADDRESS_PREDICTOR_TABLE_ASSERT_SVH
`define LOAD_ADDRESS_PREDICTOR_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define LAPT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define LAPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LAPT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define LAPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/lapt_pkg.sv =====
// Package with constants, codes and types of the load address predictor.
`default_nettype none
package lapt_pkg;
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int ADDR_BITS_DEF     = 48;
    localparam int CONF_BITS_DEF     = 8;

    localparam int SCHEME_W   = 2;
    localparam int THRESH_W   = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SCHEME_W-1:0] SCHEME_NONE   = 2'd0;
    localparam logic [SCHEME_W-1:0] SCHEME_CONST  = 2'd1;
    localparam logic [SCHEME_W-1:0] SCHEME_STRIDE = 2'd2;

    localparam logic [SCHEME_W-1:0] SCHEME_RESET = SCHEME_STRIDE;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd2;

    localparam logic REG_SCHEME = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_WRITE
    } lapt_state_t;
endpackage
`default_nettype wire

// ===== design/lapt_if.sv =====
// Handshake interfaces for load requests and prediction results.
`default_nettype none
interface lapt_req_if #(parameter int ADDR_BITS = lapt_pkg::ADDR_BITS_DEF);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] load_pc;
    logic [ADDR_BITS-1:0] actual_address;
    logic                 wrong_path;

    modport source (output valid, output load_pc, output actual_address, output wrong_path,
                    input ready);
    modport sink (input valid, input load_pc, input actual_address, input wrong_path,
                  output ready);
endinterface

interface lapt_rsp_if #(parameter int ADDR_BITS = lapt_pkg::ADDR_BITS_DEF);
    logic                 valid;
    logic                 ready;
    logic                 entry_hit;
    logic                 predicted;
    logic [ADDR_BITS-1:0] predicted_address;
    logic                 mispredicted;

    modport source (output valid, output entry_hit, output predicted,
                    output predicted_address, output mispredicted, input ready);
    modport sink (input valid, input entry_hit, input predicted,
                  input predicted_address, input mispredicted, output ready);
endinterface
`default_nettype wire

// ===== design/lapt_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module lapt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic                     wr_en,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[addr];
        end
    end
endmodule
`default_nettype wire

// ===== design/load_address_predictor_table.sv =====
// The result is registered once its load has passed the compute and write-back states.
// A new load is accepted only in the idle state, after the read-modify-write of the table RAM.
// The result register frees the input side while a result waits to be taken.
// Reset: registers return to defaults, then a clearing pass writes zero to every entry
// of the table (1024 by default); no load is accepted until it ends.
`default_nettype none
`include "load_address_predictor_table_assert.svh"
module load_address_predictor_table #(
    parameter int TABLE_ENTRIES = lapt_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = lapt_pkg::ADDR_BITS_DEF,
    parameter int CONF_BITS     = lapt_pkg::CONF_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    lapt_req_if.sink                             req,
    lapt_rsp_if.source                           rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lapt_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lapt_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lapt_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
    localparam int TAG_W    = ADDR_BITS - IDX_BITS;
    localparam int ENTRY_W  = 1 + TAG_W + ADDR_BITS + 1 + ADDR_BITS + CONF_BITS;
    localparam int CMP_W    = (CONF_BITS > lapt_pkg::THRESH_W) ? CONF_BITS
                                                               : lapt_pkg::THRESH_W;

    // Configuration registers
    logic [lapt_pkg::SCHEME_W-1:0] scheme_reg;
    logic [lapt_pkg::THRESH_W-1:0] thresh_reg;
    logic                          cfg_write;
    logic                          cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_reg <= lapt_pkg::SCHEME_RESET;
            thresh_reg <= lapt_pkg::THRESH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                lapt_pkg::REG_SCHEME: scheme_reg <= pwdata[lapt_pkg::SCHEME_W-1:0];
                lapt_pkg::REG_THRESH: thresh_reg <= pwdata[lapt_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            lapt_pkg::REG_SCHEME:
                prdata = lapt_pkg::APB_DATA_W'(scheme_reg);
            lapt_pkg::REG_THRESH:
                prdata = lapt_pkg::APB_DATA_W'(thresh_reg);
            default:
                prdata = '0;
        endcase
    end

    logic scheme_on;
    logic scheme_const;
    assign scheme_on    = (scheme_reg == lapt_pkg::SCHEME_CONST) ||
                          (scheme_reg == lapt_pkg::SCHEME_STRIDE);
    assign scheme_const = (scheme_reg == lapt_pkg::SCHEME_CONST);

    // Control
    lapt_pkg::lapt_state_t state_reg, state_next;
    logic [IDX_BITS-1:0]   clr_cnt_reg;
    logic                  req_xfer;
    logic                  out_load;
    logic                  out_valid_reg;

    assign req_xfer = req.valid && req.ready;
    assign out_load = (state_reg == lapt_pkg::ST_WRITE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lapt_pkg::ST_CLEAR:
                if (clr_cnt_reg == '1)
                begin
                    state_next = lapt_pkg::ST_IDLE;
                end
            lapt_pkg::ST_IDLE:
                if (req_xfer)
                begin
                    state_next = lapt_pkg::ST_CALC;
                end
            lapt_pkg::ST_CALC:
                state_next = lapt_pkg::ST_WRITE;
            lapt_pkg::ST_WRITE:
                if (out_load)
                begin
                    state_next = lapt_pkg::ST_IDLE;
                end
            default:
                state_next = lapt_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            lapt_pkg::ST_IDLE: req.ready = 1'b1;
            default:           req.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lapt_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lapt_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Latched load
    logic [IDX_BITS-1:0]  idx_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [ADDR_BITS-1:0] va_reg;
    logic                 off_reg;

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            idx_reg <= req.load_pc[IDX_BITS-1:0];
            tag_reg <= req.load_pc[ADDR_BITS-1:IDX_BITS];
            va_reg  <= req.actual_address;
            off_reg <= req.wrong_path;
        end
    end

    // Table RAM
    logic [IDX_BITS-1:0]  ram_addr;
    logic                 ram_we;
    logic                 ram_re;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic                 rd_valid;
    logic [TAG_W-1:0]     rd_tag;
    logic [ADDR_BITS-1:0] rd_last;
    logic                 rd_stop;
    logic [ADDR_BITS-1:0] rd_slow;
    logic [CONF_BITS-1:0] rd_conf;

    assign {rd_valid, rd_tag, rd_last, rd_stop, rd_slow, rd_conf} = ram_rdata;

    lapt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .addr    (ram_addr),
        .wr_en   (ram_we),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_data (ram_rdata)
    );

    // Compute stage: lookup result, predicted address and observed stride.
    logic                 hit_reg;
    logic                 pred_reg;
    logic [ADDR_BITS-1:0] paddr_reg;
    logic [ADDR_BITS-1:0] dlow_reg;
    logic                 dtop_reg;
    logic                 hit_c;
    logic [ADDR_BITS:0]   diff_c;

    assign hit_c  = scheme_on && rd_valid && (rd_tag == tag_reg);
    // The borrow of the subtraction is the top bit of the signed stride.
    assign diff_c = {1'b0, va_reg} - {1'b0, rd_last};

    always_ff @(posedge clk)
    begin
        if (state_reg == lapt_pkg::ST_CALC)
        begin
            hit_reg   <= hit_c;
            pred_reg  <= hit_c && (CMP_W'(rd_conf) > CMP_W'(thresh_reg));
            paddr_reg <= scheme_const ? rd_last : rd_last + rd_slow;
            dlow_reg  <= diff_c[ADDR_BITS-1:0];
            dtop_reg  <= diff_c[ADDR_BITS];
        end
    end

    // Write-back stage: training of the entry.
    logic                 train;
    logic                 same;
    logic [CONF_BITS-1:0] conf_inc;
    logic [ENTRY_W-1:0]   train_data;

    assign train    = scheme_on && !off_reg;
    assign same     = scheme_const ? (dlow_reg == '0)
                                   : ((dlow_reg == rd_slow) && (dtop_reg == rd_stop));
    assign conf_inc = (rd_conf == '1) ? rd_conf : rd_conf + 1'b1;

    always_comb
    begin
        if (!hit_reg)
        begin
            train_data = {1'b1, tag_reg, va_reg, 1'b0, {ADDR_BITS{1'b0}}, {CONF_BITS{1'b0}}};
        end
        else if (same)
        begin
            train_data = {1'b1, tag_reg, va_reg, rd_stop, rd_slow, conf_inc};
        end
        else if (scheme_const)
        begin
            train_data = {1'b1, tag_reg, va_reg, rd_stop, rd_slow, {CONF_BITS{1'b0}}};
        end
        else
        begin
            train_data = {1'b1, tag_reg, va_reg, dtop_reg, dlow_reg, {CONF_BITS{1'b0}}};
        end
    end

    always_comb
    begin
        ram_addr  = idx_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_wdata = train_data;
        case (state_reg)
            lapt_pkg::ST_CLEAR:
            begin
                ram_addr  = clr_cnt_reg;
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            lapt_pkg::ST_IDLE:
            begin
                ram_addr = req.load_pc[IDX_BITS-1:0];
                ram_re   = req_xfer;
            end
            lapt_pkg::ST_WRITE:
                ram_we = out_load && train;
            default: ;
        endcase
    end

    // Result register
    logic                 out_hit_reg;
    logic                 out_pred_reg;
    logic [ADDR_BITS-1:0] out_paddr_reg;
    logic                 out_mis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg   <= hit_reg;
            out_pred_reg  <= pred_reg;
            out_paddr_reg <= pred_reg ? paddr_reg : '0;
            out_mis_reg   <= pred_reg && (paddr_reg != va_reg);
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.entry_hit         = out_hit_reg;
    assign rsp.predicted         = out_pred_reg;
    assign rsp.predicted_address = out_paddr_reg;
    assign rsp.mispredicted      = out_mis_reg;

    `LAPT_ASSERT_NEXT(a_accept_calc, clk, rst_n, req_xfer, state_reg == lapt_pkg::ST_CALC)
    `LAPT_ASSERT_IMPLIES(a_pred_hit, clk, rst_n, rsp.valid && rsp.predicted, rsp.entry_hit)
    `LAPT_ASSERT_IMPLIES(a_mis_pred, clk, rst_n, rsp.valid && rsp.mispredicted, rsp.predicted)
    `LAPT_ASSERT_IMPLIES(a_ram_wr, clk, rst_n, ram_we, (state_reg == lapt_pkg::ST_CLEAR) || (state_reg == lapt_pkg::ST_WRITE))
endmodule
`default_nettype wire
